// ===== rtl/alks_pkg.sv =====
// Package for the ADC ladder key scanner: command and event codes, reset values
// of the configuration registers and the event code helper.
// No dependencies; compile first.
`default_nettype none

package alks_pkg;

  // Command field of an input item
  localparam logic CMD_SCAN = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] REG_THR_LOW  = 3'd0;
  localparam logic [2:0] REG_THR_HIGH = 3'd1;
  localparam logic [2:0] REG_FILTER   = 3'd2;
  localparam logic [2:0] REG_LONG     = 3'd3;
  localparam logic [2:0] REG_REPEAT   = 3'd4;

  // Event kinds, added to 5 * key
  localparam logic [2:0] KIND_PRESS         = 3'd1;
  localparam logic [2:0] KIND_SHORT_RELEASE = 3'd2;
  localparam logic [2:0] KIND_LONG_PRESS    = 3'd3;
  localparam logic [2:0] KIND_REPEAT        = 3'd4;
  localparam logic [2:0] KIND_LONG_RELEASE  = 3'd5;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned CODE_W   = 6;
  localparam int unsigned CFG_W    = 48;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned FILTER_W = 6;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned LONG_W   = 10;
  localparam int unsigned REPEAT_W = 8;

  localparam logic [FILTER_W-1:0] FILTER_RESET = 6'd5;
  localparam logic [LONG_W-1:0]   LONG_RESET   = 10'd100;
  localparam logic [REPEAT_W-1:0] REPEAT_RESET = 8'd10;
  localparam logic [COUNT_W-1:0]  COUNT_RESET  = COUNT_W'(FILTER_RESET / 2);

  localparam int unsigned NUM_KEYS_DEFAULT   = 8;
  localparam int unsigned FIFO_DEPTH_DEFAULT = 16;

  // Event code 5 * key + kind
  function automatic logic [CODE_W-1:0] key_event(input logic [2:0] key,
                                                  input logic [2:0] kind);
    return {1'b0, key, 2'b00} + {3'b000, key} + {3'b000, kind};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/alks_if.sv =====
// Valid/ready channel interfaces of the ADC ladder key scanner: scan/read
// requests, popped key codes and configuration writes. Uses alks_pkg.
`default_nettype none

interface alks_req_if import alks_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                cmd;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output cmd, output sample, input ready);
  modport sink   (input valid, input cmd, input sample, output ready);
endinterface

interface alks_rsp_if import alks_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] key_code;
  logic              events_lost;

  modport source (output valid, output key_code, output events_lost, input ready);
  modport sink   (input valid, input key_code, input events_lost, output ready);
endinterface

interface alks_cfg_if import alks_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [CFG_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/adc_ladder_key_scanner.sv =====
// Top level of the ADC ladder key scanner: key walk sequencer, per-key
// debounce/hold/repeat counters and the event code FIFO.
// Depends on alks_pkg and the channel interfaces in alks_if.sv.
`default_nettype none

// Usage:
//   req_i  : one transfer is a scan (cmd = CMD_SCAN, with an ADC sample) or a
//            read (cmd = CMD_READ). ready is high only while the block is idle.
//   rsp_o  : one transfer per read, carrying the popped key code (0 when the
//            FIFO is empty) and the events-lost flag, which the read clears.
//   cfg_i  : register writes, always ready; write only while the block is idle.
// Timing:
//   A scan walks the keys one per cycle through one shared compare and counter
//   unit, with an extra ST_PUSH2 step for each key that emits a press and a
//   long press in the same tick, then returns to idle, where the next request
//   is taken. A scan gives no result. A read passes through ST_READ, which
//   loads the output register that drives rsp_o.valid, then returns to idle;
//   while the receiver stalls, a read waits in its own state with req_i.ready low.
// Reset:
//   Counters, flags, FIFO pointers and registers go to their reset values
//   (filter 5, long 100, repeat 10, thresholds 0). FIFO storage is not cleared;
//   only pushed entries are ever popped. No clearing pass is needed.
module adc_ladder_key_scanner import alks_pkg::*; #(
  parameter int unsigned NUM_KEYS   = NUM_KEYS_DEFAULT,
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEFAULT
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  alks_req_if.sink   req_i,
  alks_rsp_if.source rsp_o,
  alks_cfg_if.sink   cfg_i
);

  localparam int unsigned KEY_W  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int unsigned PTR_W  = $clog2(FIFO_DEPTH);
  localparam int unsigned FILL_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_PUSH2,
    ST_READ
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [CFG_W-1:0]    thr_low_q, thr_high_q;
  logic [FILTER_W-1:0] filter_q;
  logic [LONG_W-1:0]   long_q;
  logic [REPEAT_W-1:0] repeat_q;

  // Per-key state
  logic [COUNT_W-1:0]  dbc_q  [NUM_KEYS];
  logic                down_q [NUM_KEYS];
  logic [LONG_W-1:0]   hold_q [NUM_KEYS];
  logic [REPEAT_W-1:0] rep_q  [NUM_KEYS];

  // Walk sequencer
  logic [KEY_W-1:0]    idx_q;
  logic                found_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic [CODE_W-1:0]   code2_q;

  // Event FIFO
  logic [CODE_W-1:0] fifo_mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]  head_q, tail_q;
  logic [FILL_W-1:0] fill_q;
  logic              lost_q;

  // Output register
  logic              out_valid_q;
  logic [CODE_W-1:0] key_code_q;
  logic              events_lost_q;

  // Thresholds unpacked per key
  logic [SAMPLE_W-1:0] thr_arr [NUM_KEYS];
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_thr
    if (k < 4) begin : g_low
      assign thr_arr[k] = thr_low_q[SAMPLE_W*k +: SAMPLE_W];
    end else begin : g_high
      assign thr_arr[k] = thr_high_q[SAMPLE_W*(k-4) +: SAMPLE_W];
    end
  end

  // Shared per-key update unit, working on key idx_q
  logic                key_active;
  logic [COUNT_W-1:0]  f_ext, f_twice, cnt, n_cnt;
  logic                kd, n_kd;
  logic [LONG_W-1:0]   hold, n_hold;
  logic [REPEAT_W-1:0] rep, n_rep;
  logic                push1, push2;
  logic [CODE_W-1:0]   code1, code2;
  logic [2:0]          key3;

  always_comb begin
    key3       = 3'(idx_q);
    key_active = !found_q && (sample_q < thr_arr[idx_q]);
    f_ext      = {1'b0, filter_q};
    f_twice    = {filter_q, 1'b0};
    cnt        = dbc_q[idx_q];
    kd         = down_q[idx_q];
    hold       = hold_q[idx_q];
    rep        = rep_q[idx_q];
    n_cnt      = cnt;
    n_kd       = kd;
    n_hold     = hold;
    n_rep      = rep;
    push1      = 1'b0;
    push2      = 1'b0;
    code1      = '0;
    code2      = '0;
    if (key_active) begin
      if (cnt < f_ext) begin
        n_cnt = f_ext;
      end else if (cnt < f_twice) begin
        n_cnt = cnt + 1'b1;
      end else begin
        if (!kd) begin
          n_kd  = 1'b1;
          push1 = 1'b1;
          code1 = key_event(key3, KIND_PRESS);
        end
        if (long_q != '0) begin
          if (hold < long_q) begin
            n_hold = hold + 1'b1;
            if (n_hold >= long_q) begin
              // A press in the same tick takes the first slot
              if (push1) begin
                push2 = 1'b1;
                code2 = key_event(key3, KIND_LONG_PRESS);
              end else begin
                push1 = 1'b1;
                code1 = key_event(key3, KIND_LONG_PRESS);
              end
            end
          end else if (repeat_q != '0) begin
            n_rep = rep + 1'b1;
            if (n_rep >= repeat_q) begin
              n_rep = '0;
              push1 = 1'b1;
              code1 = key_event(key3, KIND_REPEAT);
            end
          end
        end
      end
    end else begin
      if (cnt > f_ext) begin
        n_cnt = f_ext;
      end else if (cnt != '0) begin
        n_cnt = cnt - 1'b1;
      end else if (kd) begin
        n_kd   = 1'b0;
        push1  = 1'b1;
        code1  = key_event(key3, (hold >= long_q) ? KIND_LONG_RELEASE
                                                  : KIND_SHORT_RELEASE);
        n_hold = '0;
      end
      n_rep = '0;
    end
  end

  // FIFO push/pop control
  logic              fifo_full, push_en, pop_en, load_out, last_key;
  logic [CODE_W-1:0] push_code;

  always_comb begin
    fifo_full = (fill_q == FILL_W'(FIFO_DEPTH));
    push_en   = ((state_q == ST_WALK) && push1) || (state_q == ST_PUSH2);
    push_code = (state_q == ST_PUSH2) ? code2_q : code1;
    load_out  = (state_q == ST_READ) && (!out_valid_q || rsp_o.ready);
    pop_en    = load_out && (fill_q != '0);
    last_key  = (idx_q == KEY_W'(NUM_KEYS - 1));
  end

  assign req_i.ready       = (state_q == ST_IDLE);
  assign cfg_i.ready       = 1'b1;
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.key_code    = key_code_q;
  assign rsp_o.events_lost = events_lost_q;

  // Control state, counters and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      thr_low_q   <= '0;
      thr_high_q  <= '0;
      filter_q    <= FILTER_RESET;
      long_q      <= LONG_RESET;
      repeat_q    <= REPEAT_RESET;
      for (int k = 0; k < NUM_KEYS; k++) begin
        dbc_q[k]  <= COUNT_RESET;
        down_q[k] <= 1'b0;
        hold_q[k] <= '0;
        rep_q[k]  <= '0;
      end
      idx_q       <= '0;
      found_q     <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      fill_q      <= '0;
      lost_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          REG_THR_LOW:  thr_low_q  <= cfg_i.data;
          REG_THR_HIGH: thr_high_q <= cfg_i.data;
          REG_FILTER:   filter_q   <= cfg_i.data[FILTER_W-1:0];
          REG_LONG:     long_q     <= cfg_i.data[LONG_W-1:0];
          REG_REPEAT:   repeat_q   <= cfg_i.data[REPEAT_W-1:0];
          default: ;
        endcase
      end

      // Drop the result once transferred, unless a new load replaces it
      if (out_valid_q && rsp_o.ready && !load_out) begin
        out_valid_q <= 1'b0;
      end

      // Push or drop one event
      if (push_en) begin
        if (fifo_full) begin
          lost_q <= 1'b1;
        end else begin
          tail_q <= (tail_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : tail_q + 1'b1;
          fill_q <= fill_q + 1'b1;
        end
      end

      unique case (state_q)
        ST_IDLE: begin
          if (req_i.valid) begin
            idx_q   <= '0;
            found_q <= 1'b0;
            state_q <= (req_i.cmd == CMD_READ) ? ST_READ : ST_WALK;
          end
        end
        ST_WALK: begin
          dbc_q[idx_q]  <= n_cnt;
          down_q[idx_q] <= n_kd;
          hold_q[idx_q] <= n_hold;
          rep_q[idx_q]  <= n_rep;
          found_q       <= found_q | key_active;
          if (push2) begin
            state_q <= ST_PUSH2;
          end else if (last_key) begin
            state_q <= ST_IDLE;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_PUSH2: begin
          if (last_key) begin
            state_q <= ST_IDLE;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= ST_WALK;
          end
        end
        ST_READ: begin
          if (load_out) begin
            out_valid_q <= 1'b1;
            lost_q      <= 1'b0;
            if (pop_en) begin
              head_q <= (head_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_q + 1'b1;
              fill_q <= fill_q - 1'b1;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Payload: FIFO storage, captured sample, second code and output data
  always_ff @(posedge clk_i) begin
    if (push_en && !fifo_full) begin
      fifo_mem_q[tail_q] <= push_code;
    end
    if (req_i.valid && req_i.ready) begin
      sample_q <= req_i.sample;
    end
    if (state_q == ST_WALK) begin
      code2_q <= code2;
    end
    if (load_out) begin
      key_code_q    <= pop_en ? fifo_mem_q[head_q] : '0;
      events_lost_q <= lost_q;
    end
  end

endmodule

`default_nettype wire
